/* rtl/lmsd_pkg.sv */
// ----------------------------------------------------------------------------
// lmsd_pkg
// Shared types and constants of the LED matrix scan driver.
// ----------------------------------------------------------------------------
package lmsd_pkg;

   localparam int LINE_BITS_DEF = 32;
   localparam int SCAN_ROWS_DEF = 8;

   localparam logic [15:0] LATCH_HOLD_RESET = 16'd100;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [3:0]  line_select;
      logic [31:0] line_bits;
   } req_type;

   typedef struct packed {
      logic [2:0] row_address;
      logic       red_top;
      logic       red_bottom;
      logic       shift_strobe;
      logic       blank;
      logic       latch;
      logic       frame_end;
   } rsp_type;

   // What the scan sequencer drives for the tick it is stepping through.
   typedef struct packed {
      logic       shift_on;
      logic       latch_on;
      logic       gap_on;
      logic [2:0] row_address;
   } scan_ctrl_type;

endpackage

/* rtl/led_matrix_scan_driver.sv */
// ----------------------------------------------------------------------------
// led_matrix_scan_driver
// Refresh scanner for a 1/8-scan single-color LED panel with a line store.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction | beat
//  req     | req_valid/req_ready/req_data   | in        | tick or line write
//  rsp     | rsp_valid/rsp_ready/rsp_data   | out       | one pin snapshot
//  csr     | csr_wr_en/csr_wr_data          | in        | latch hold ticks
//
// One beat is taken every cycle while req_ready is high; each result passes
// through the read stage for the line store read, then the output register.
// Reset is synchronous and clears the scan state, the latch hold register
// (to 100) and the line valid bits; unwritten lines read as the power-up
// pattern at once, so there is no clearing pass.
// A stalled rsp side holds the read stage, and req_ready drops only when
// both the read stage and the output register are full and rsp_ready is low.
// ----------------------------------------------------------------------------
module led_matrix_scan_driver #(
   parameter int LINE_BITS = lmsd_pkg::LINE_BITS_DEF,
   parameter int SCAN_ROWS = lmsd_pkg::SCAN_ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lmsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lmsd_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);
   import lmsd_pkg::*;

   localparam int ROW_W = $clog2(SCAN_ROWS);
   localparam int BIT_W = $clog2(LINE_BITS);

   logic [15:0] latch_hold_ff;

   logic        req_fire, tick_fire, write_fire, s1_move;
   logic        out_free;

   logic [6:0]       sel_ext;
   logic             sel_top, sel_bot;
   logic [ROW_W-1:0] wr_addr_top, wr_addr_bot;
   logic [LINE_BITS-1:0] wr_line;

   scan_ctrl_type    ctrl;
   logic [ROW_W-1:0] scan_row;
   logic [BIT_W-1:0] bit_sel;

   logic [LINE_BITS-1:0] rd_top, rd_bot;
   logic [SCAN_ROWS-1:0] top_vld_ff, bot_vld_ff;

   logic             s1_valid_ff;
   logic             s1_write_ff;
   scan_ctrl_type    s1_ctrl_ff;
   logic [BIT_W-1:0] s1_bit_ff;
   logic             s1_top_vld_ff, s1_bot_vld_ff, s1_row0_ff;

   logic    bit_top, bit_bot;
   rsp_type pins, held_ff, rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || out_free;
   assign req_fire   = req_valid && req_ready;
   assign tick_fire  = req_fire && (req_data.mode == MODE_TICK);
   assign write_fire = req_fire && (req_data.mode == MODE_WRITE);
   assign s1_move    = s1_valid_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_hold_ff <= LATCH_HOLD_RESET;
      end else if (csr_wr_en) begin
         latch_hold_ff <= csr_wr_data;
      end
   end

   // Line writes: lines below SCAN_ROWS go to the top store, the next
   // SCAN_ROWS to the bottom store, anything beyond is dropped.
   assign sel_ext     = 7'(req_data.line_select);
   assign sel_top     = sel_ext < 7'(SCAN_ROWS);
   assign sel_bot     = !sel_top && (sel_ext < 7'(2 * SCAN_ROWS));
   assign wr_addr_top = ROW_W'(sel_ext);
   assign wr_addr_bot = ROW_W'(sel_ext - 7'(SCAN_ROWS));
   assign wr_line     = LINE_BITS'(req_data.line_bits);

   lmsd_sequencer #(
      .LINE_BITS(LINE_BITS),
      .SCAN_ROWS(SCAN_ROWS)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .step       (tick_fire),
      .hold_ticks (latch_hold_ff),
      .ctrl       (ctrl),
      .row        (scan_row),
      .bit_sel    (bit_sel)
   );

   lmsd_ram #(
      .WIDTH(LINE_BITS),
      .DEPTH(SCAN_ROWS)
   ) u_ram_top (
      .clock   (clock),
      .wr_en   (write_fire && sel_top),
      .wr_addr (wr_addr_top),
      .wr_data (wr_line),
      .rd_en   (tick_fire),
      .rd_addr (scan_row),
      .rd_data (rd_top)
   );

   lmsd_ram #(
      .WIDTH(LINE_BITS),
      .DEPTH(SCAN_ROWS)
   ) u_ram_bot (
      .clock   (clock),
      .wr_en   (write_fire && sel_bot),
      .wr_addr (wr_addr_bot),
      .wr_data (wr_line),
      .rd_en   (tick_fire),
      .rd_addr (scan_row),
      .rd_data (rd_bot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         top_vld_ff <= '0;
         bot_vld_ff <= '0;
      end else if (write_fire) begin
         if (sel_top) begin
            top_vld_ff[wr_addr_top] <= 1'b1;
         end
         if (sel_bot) begin
            bot_vld_ff[wr_addr_bot] <= 1'b1;
         end
      end
   end

   // Read stage: holds the scan step while the store read completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_write_ff   <= (req_data.mode == MODE_WRITE);
         s1_ctrl_ff    <= ctrl;
         s1_bit_ff     <= bit_sel;
         s1_top_vld_ff <= top_vld_ff[scan_row];
         s1_bot_vld_ff <= bot_vld_ff[scan_row];
         s1_row0_ff    <= (scan_row == '0);
      end
   end

   // A never-written top line 0 reads as only its leftmost pixel lit.
   assign bit_top = s1_top_vld_ff ? rd_top[s1_bit_ff]
                  : (s1_row0_ff && s1_bit_ff == BIT_W'(LINE_BITS - 1));
   assign bit_bot = s1_bot_vld_ff && rd_bot[s1_bit_ff];

   assign pins.row_address  = s1_ctrl_ff.row_address;
   assign pins.red_top      = s1_ctrl_ff.shift_on && bit_top;
   assign pins.red_bottom   = s1_ctrl_ff.shift_on && bit_bot;
   assign pins.shift_strobe = s1_ctrl_ff.shift_on;
   assign pins.blank        = s1_ctrl_ff.shift_on;
   assign pins.latch        = s1_ctrl_ff.latch_on;
   assign pins.frame_end    = s1_ctrl_ff.gap_on;

   // A write beat repeats the last tick's pins without strobe or frame mark.
   always_comb begin
      rsp_in = pins;
      if (s1_write_ff) begin
         rsp_in              = held_ff;
         rsp_in.shift_strobe = 1'b0;
         rsp_in.frame_end    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_move && !s1_write_ff) begin
            held_ff <= pins;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_read_stage_kept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_ctrl_ff))
      else $error("read stage lost or changed while the output was stalled");

   a_latch_unblanked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.latch |-> !rsp_ff.blank && !rsp_ff.shift_strobe)
      else $error("latch driven while the panel is blanked or shifting");

   a_frame_end_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_end |-> !rsp_ff.blank && !rsp_ff.latch)
      else $error("frame end beat carries shift or latch activity");

endmodule

/* rtl/lmsd_ram.sv */
// ----------------------------------------------------------------------------
// lmsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lmsd_sequencer.sv */
// ----------------------------------------------------------------------------
// lmsd_sequencer
// Row scan state machine: shift phase, latch hold phase and frame gap tick.
// ----------------------------------------------------------------------------
module lmsd_sequencer #(
   parameter int LINE_BITS = lmsd_pkg::LINE_BITS_DEF,
   parameter int SCAN_ROWS = lmsd_pkg::SCAN_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [15:0]                   hold_ticks,
   output lmsd_pkg::scan_ctrl_type       ctrl,
   output logic [$clog2(SCAN_ROWS)-1:0]  row,
   output logic [$clog2(LINE_BITS)-1:0]  bit_sel
);
   import lmsd_pkg::*;

   localparam int ROW_W = $clog2(SCAN_ROWS);
   localparam int BIT_W = $clog2(LINE_BITS);

   localparam logic [1:0] PH_SHIFT = 2'd0;
   localparam logic [1:0] PH_HOLD  = 2'd1;
   localparam logic [1:0] PH_GAP   = 2'd2;

   logic [1:0]       phase_ff, phase_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [BIT_W-1:0] bitpos_ff, bitpos_in;
   logic [15:0]      hold_ff, hold_in;
   logic [15:0]      hold_dec;

   assign hold_dec = (hold_ff != 16'd0) ? hold_ff - 16'd1 : 16'd0;

   always_comb begin
      phase_in  = phase_ff;
      row_in    = row_ff;
      bitpos_in = bitpos_ff;
      hold_in   = hold_ff;
      case (phase_ff)
         PH_SHIFT: begin
            if (bitpos_ff == BIT_W'(LINE_BITS - 1)) begin
               bitpos_in = '0;
               phase_in  = PH_HOLD;
               // A zero hold setting still gives one latch tick.
               hold_in   = (hold_ticks != 16'd0) ? hold_ticks : 16'd1;
            end else begin
               bitpos_in = bitpos_ff + BIT_W'(1);
            end
         end
         PH_HOLD: begin
            hold_in = hold_dec;
            if (hold_dec == 16'd0) begin
               if (row_ff == ROW_W'(SCAN_ROWS - 1)) begin
                  phase_in = PH_GAP;
               end else begin
                  row_in   = row_ff + ROW_W'(1);
                  phase_in = PH_SHIFT;
               end
            end
         end
         default: begin
            row_in    = '0;
            bitpos_in = '0;
            phase_in  = PH_SHIFT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SHIFT;
         row_ff    <= '0;
         bitpos_ff <= '0;
         hold_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         row_ff    <= row_in;
         bitpos_ff <= bitpos_in;
         hold_ff   <= hold_in;
      end
   end

   assign ctrl.shift_on    = (phase_ff == PH_SHIFT);
   assign ctrl.latch_on    = (phase_ff == PH_HOLD);
   assign ctrl.gap_on      = (phase_ff == PH_GAP);
   assign ctrl.row_address = 3'(row_ff);
   assign row              = row_ff;
   assign bit_sel          = BIT_W'(LINE_BITS - 1) - bitpos_ff;

   a_bitpos_shift_only: assert property (@(posedge clock) disable iff (reset)
      bitpos_ff != '0 |-> phase_ff == PH_SHIFT)
      else $error("bit position left nonzero outside the shift phase");

   a_hold_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HOLD |-> hold_ff != 16'd0)
      else $error("hold phase entered with an empty hold count");

   a_gap_one_tick: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_GAP |=> phase_ff == PH_SHIFT && row_ff == '0)
      else $error("gap tick did not restart the frame at row 0");

endmodule
